>>> rtl/ptst_pkg.sv
// Shared types and constants for the periodic timer slot table.
`default_nettype none

package ptst_pkg;

   // Slot table geometry.
   localparam int SLOTS  = 16;
   localparam int SLOT_W = 4;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
   localparam logic [7:0] SLOTS_IDX = 8'(SLOTS);

   // Command codes carried on the request channel.
   typedef logic [1:0] cmd_type;
   localparam cmd_type CMD_TICK  = 2'd0;
   localparam cmd_type CMD_REG   = 2'd1;
   localparam cmd_type CMD_UNREG = 2'd2;

   // Result kinds carried on the response channel.
   typedef logic [1:0] kind_type;
   localparam kind_type KIND_FIRED     = 2'd0;
   localparam kind_type KIND_REG       = 2'd1;
   localparam kind_type KIND_UNREG     = 2'd2;
   localparam kind_type KIND_TICK_DONE = 2'd3;

   // Result status codes.
   typedef logic [1:0] status_type;
   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_OOM       = 2'd1;
   localparam status_type ST_BAD_INDEX = 2'd2;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CHECK,
      ST_DONE,
      ST_REPLY
   } state_type;

endpackage

`default_nettype wire

>>> rtl/periodic_timer_slot_table.sv
// Top level of the periodic timer slot table core.
`default_nettype none

// Channel   Dir  Handshake              Payload
// req       in   req_tvalid/req_tready  tuser command, tdata time/period/index/flags
// rsp       out  rsp_tvalid/rsp_tready  tuser kind, tdata slot/status, tlast last
//
// A register or unregister item passes from its transfer through the REPLY
// state into the response register; a stall on the response side holds it in
// REPLY. A tick makes one read of the slot memory per slot, gives one result
// per fired slot, and ends with the tick-done result. The scan issues one read
// each cycle on the single read port of the slot memories, and a stalled
// response holds the scan on the slot that fired. Reset (synchronous, active
// high) frees all slots at once; the period and expiry memories need no
// clearing because a slot is only looked at once a register item wrote it.
// A new request is taken only when the sequencer is idle, but a finished
// result may still wait in the response register while it does so.

module periodic_timer_slot_table_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [31:0] now_time, [63:32] period, [71:64] slot_index,
   // [72] has_handler, [73] has_context, [79:74] zero
   input  wire logic [79:0] req_tdata,
   // [1:0] command
   input  wire logic [1:0]  req_tuser,
   // Response channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [3:0] slot, [5:4] status, [7:6] zero
   output logic [7:0]       rsp_tdata,
   // [1:0] kind
   output logic [1:0]       rsp_tuser,
   output logic             rsp_tlast
);

   ptst_pkg::state_type state_ff, state_in;

   // Latched request.
   ptst_pkg::cmd_type cmd_ff, cmd_in;
   logic [31:0] now_ff, now_in;
   logic [31:0] period_ff, period_in;
   logic [7:0]  idx_ff, idx_in;
   logic        handler_ff, handler_in;
   logic        ctx_ff, ctx_in;

   // Scan position during a tick.
   logic [ptst_pkg::SLOT_W-1:0] scan_ff, scan_in;

   // Per-slot flags, cleared at reset.
   logic [ptst_pkg::SLOTS-1:0] active_ff, active_in;
   logic [ptst_pkg::SLOTS-1:0] slot_ctx_ff, slot_ctx_in;

   // Response register.
   logic                  rsp_valid_ff, rsp_valid_in;
   ptst_pkg::kind_type    rsp_kind_ff, rsp_kind_in;
   logic [ptst_pkg::SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   ptst_pkg::status_type  rsp_status_ff, rsp_status_in;
   logic                  rsp_last_ff, rsp_last_in;

   // Slot memories: period and last expiry time, one write and one read port.
   logic [31:0] period_mem [ptst_pkg::SLOTS];
   logic [31:0] expiry_mem [ptst_pkg::SLOTS];
   logic [31:0] period_rd_ff;
   logic [31:0] expiry_rd_ff;
   logic [ptst_pkg::SLOT_W-1:0] rd_addr;
   logic [ptst_pkg::SLOT_W-1:0] wr_addr;
   logic        period_we;
   logic        expiry_we;
   logic [31:0] period_wdata;
   logic [31:0] expiry_wdata;

   logic        out_free;
   logic        fire;
   logic [31:0] elapsed;
   logic        free_found;
   logic [ptst_pkg::SLOT_W-1:0] free_slot;

   // Lowest free slot.
   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = ptst_pkg::SLOTS - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_found = 1'b1;
            free_slot  = ptst_pkg::SLOT_W'(i);
         end
      end
   end

   // A slot fires when it is active, has a context and a nonzero period, and its
   // elapsed time, modulo 2^32, strictly exceeds its period.
   assign elapsed = now_ff - expiry_rd_ff;
   assign fire    = active_ff[scan_ff] && slot_ctx_ff[scan_ff] &&
                    (period_rd_ff != 32'd0) && (elapsed > period_rd_ff);

   // The response register can take a new result when it is empty or drains.
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      now_in        = now_ff;
      period_in     = period_ff;
      idx_in        = idx_ff;
      handler_in    = handler_ff;
      ctx_in        = ctx_ff;
      scan_in       = scan_ff;
      active_in     = active_ff;
      slot_ctx_in   = slot_ctx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      rd_addr       = scan_ff;
      wr_addr       = scan_ff;
      period_we     = 1'b0;
      expiry_we     = 1'b0;
      period_wdata  = period_ff;
      expiry_wdata  = now_ff;
      req_tready    = (state_ff == ptst_pkg::ST_IDLE);

      unique case (state_ff)
         ptst_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in     = req_tuser;
               now_in     = req_tdata[31:0];
               period_in  = req_tdata[63:32];
               idx_in     = req_tdata[71:64];
               handler_in = req_tdata[72];
               ctx_in     = req_tdata[73];
               unique case (req_tuser) inside
                  ptst_pkg::CMD_TICK: begin
                     scan_in  = '0;
                     state_in = ptst_pkg::ST_SCAN;
                  end
                  ptst_pkg::CMD_REG, ptst_pkg::CMD_UNREG: begin
                     state_in = ptst_pkg::ST_REPLY;
                  end
                  default: begin
                     // Unknown commands are dropped without a result.
                     state_in = ptst_pkg::ST_IDLE;
                  end
               endcase
            end
         end

         ptst_pkg::ST_SCAN: begin
            // Read of slot zero is in flight.
            state_in = ptst_pkg::ST_CHECK;
         end

         ptst_pkg::ST_CHECK: begin
            if (fire && out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = ptst_pkg::KIND_FIRED;
               rsp_slot_in   = scan_ff;
               rsp_status_in = ptst_pkg::ST_OK;
               rsp_last_in   = 1'b0;
               expiry_we     = 1'b1;
            end
            if (!fire || out_free) begin
               if (scan_ff == ptst_pkg::LAST_SLOT) begin
                  state_in = ptst_pkg::ST_DONE;
               end else begin
                  scan_in = ptst_pkg::SLOT_W'(scan_ff + 1'b1);
                  rd_addr = scan_in;
               end
            end
         end

         ptst_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = ptst_pkg::KIND_TICK_DONE;
               rsp_slot_in   = '0;
               rsp_status_in = ptst_pkg::ST_OK;
               rsp_last_in   = 1'b1;
               state_in      = ptst_pkg::ST_IDLE;
            end
         end

         ptst_pkg::ST_REPLY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               rsp_slot_in  = '0;
               state_in     = ptst_pkg::ST_IDLE;
               if (cmd_ff == ptst_pkg::CMD_REG) begin
                  rsp_kind_in = ptst_pkg::KIND_REG;
                  if (free_found) begin
                     // A register without a handler still writes the slot.
                     wr_addr                = free_slot;
                     period_we              = 1'b1;
                     expiry_we              = 1'b1;
                     expiry_wdata           = 32'd0;
                     active_in[free_slot]   = handler_ff;
                     slot_ctx_in[free_slot] = ctx_ff;
                     rsp_slot_in            = free_slot;
                     rsp_status_in          = ptst_pkg::ST_OK;
                  end else begin
                     rsp_status_in = ptst_pkg::ST_OOM;
                  end
               end else begin
                  rsp_kind_in = ptst_pkg::KIND_UNREG;
                  // Negative indexes read as 128 and above, so one compare
                  // rejects them too.
                  if (idx_ff < ptst_pkg::SLOTS_IDX) begin
                     active_in[idx_ff[ptst_pkg::SLOT_W-1:0]] = 1'b0;
                     rsp_slot_in   = idx_ff[ptst_pkg::SLOT_W-1:0];
                     rsp_status_in = ptst_pkg::ST_OK;
                  end else begin
                     rsp_status_in = ptst_pkg::ST_BAD_INDEX;
                  end
               end
            end
         end

         default: begin
            state_in = ptst_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptst_pkg::ST_IDLE;
         active_ff    <= '0;
         slot_ctx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         slot_ctx_ff  <= slot_ctx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      now_ff        <= now_in;
      period_ff     <= period_in;
      idx_ff        <= idx_in;
      handler_ff    <= handler_in;
      ctx_ff        <= ctx_in;
      scan_ff       <= scan_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Slot memories with registered read data.
   always_ff @(posedge clock) begin
      if (period_we) begin
         period_mem[wr_addr] <= period_wdata;
      end
      if (expiry_we) begin
         expiry_mem[wr_addr] <= expiry_wdata;
      end
      period_rd_ff <= period_mem[rd_addr];
      expiry_rd_ff <= expiry_mem[rd_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_status_ff, rsp_slot_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   // While the scan goes on, the expiry write-back of a fired slot never lands
   // on the entry read for the next check.
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (expiry_we && state_ff == ptst_pkg::ST_CHECK && state_in == ptst_pkg::ST_CHECK)
      |-> (rd_addr != wr_addr))
      else $error("slot memory read and write hit the same entry during a scan");

   // Fired results never close a tick; tick-done always does.
   a_fired_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ptst_pkg::KIND_FIRED) |-> !rsp_tlast)
      else $error("fired result marked as last");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ptst_pkg::KIND_TICK_DONE) |-> rsp_tlast)
      else $error("tick-done result not marked as last");

   // A result is only loaded while the sequencer is working on an item.
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> ($past(state_ff) != ptst_pkg::ST_IDLE &&
                             $past(state_ff) != ptst_pkg::ST_SCAN))
      else $error("result appeared without an item in progress");

endmodule

`default_nettype wire

>>> sim/ptst_checker.sv
// Checker for the periodic timer slot table: predicts every result and compares it.
`timescale 1ns / 100ps

module ptst_checker
   import ptst_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [79:0] req_tdata,
   input  wire logic [1:0]  req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [7:0]  rsp_tdata,
   input  wire logic [1:0]  rsp_tuser,
   input  wire logic        rsp_tlast,
   output int               mismatches,
   output int               outstanding
);

   typedef struct packed {
      kind_type          kind;
      logic [SLOT_W-1:0] slot;
      status_type        status;
      logic              last;
   } slot_result_type;

   // Results the table owes us, oldest first.
   slot_result_type due_results[$];

   // Shadow copy of the slot table.
   logic        shadow_active [SLOTS];
   logic        shadow_ctx    [SLOTS];
   logic [31:0] shadow_period [SLOTS];
   logic [31:0] shadow_expiry [SLOTS];

   function automatic slot_result_type result_of(kind_type kind, int slot,
                                                 status_type status, logic last);
      slot_result_type r;
      r.kind   = kind;
      r.slot   = SLOT_W'(slot);
      r.status = status;
      r.last   = last;
      return r;
   endfunction

   // Applies one accepted request to the shadow table and queues its results.
   task automatic run_slot_table(input cmd_type cmd, input logic [79:0] data);
      logic [31:0] now_ms;
      logic [31:0] period_ms;
      logic [7:0]  index;
      int          free_slot;
      now_ms    = data[31:0];
      period_ms = data[63:32];
      index     = data[71:64];
      free_slot = SLOTS;
      case (cmd)
         CMD_TICK: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (shadow_active[i] && shadow_ctx[i] && shadow_period[i] != 32'd0 &&
                   (now_ms - shadow_expiry[i]) > shadow_period[i]) begin
                  shadow_expiry[i] = now_ms;
                  due_results.push_back(result_of(KIND_FIRED, i, ST_OK, 1'b0));
               end
            end
            due_results.push_back(result_of(KIND_TICK_DONE, 0, ST_OK, 1'b1));
         end
         CMD_REG: begin
            for (int i = SLOTS - 1; i >= 0; i--) begin
               if (!shadow_active[i]) free_slot = i;
            end
            if (free_slot < SLOTS) begin
               shadow_expiry[free_slot] = 32'd0;
               shadow_active[free_slot] = data[72];
               shadow_period[free_slot] = period_ms;
               shadow_ctx[free_slot]    = data[73];
               due_results.push_back(result_of(KIND_REG, free_slot, ST_OK, 1'b1));
            end else begin
               due_results.push_back(result_of(KIND_REG, 0, ST_OOM, 1'b1));
            end
         end
         CMD_UNREG: begin
            // The index is two's complement, so bit 7 set means negative.
            if (!index[7] && index < SLOTS_IDX) begin
               shadow_active[index] = 1'b0;
               due_results.push_back(result_of(KIND_UNREG, int'(index), ST_OK, 1'b1));
            end else begin
               due_results.push_back(result_of(KIND_UNREG, 0, ST_BAD_INDEX, 1'b1));
            end
         end
         default: ;
      endcase
   endtask

   task automatic compare_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatches = mismatches + 1;
      end
   endtask

   always @(posedge clock) begin
      slot_result_type oldest;
      if (reset) begin
         due_results.delete();
         mismatches = 0;
         for (int i = 0; i < SLOTS; i++) begin
            shadow_active[i] = 1'b0;
            shadow_ctx[i]    = 1'b0;
            shadow_period[i] = 32'd0;
            shadow_expiry[i] = 32'd0;
         end
      end else begin
         if (req_tvalid && req_tready) run_slot_table(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (due_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual kind %0d slot %0d",
                        $time, rsp_tuser, rsp_tdata[3:0]);
               mismatches = mismatches + 1;
            end else begin
               oldest = due_results.pop_front();
               compare_field("kind", oldest.kind, rsp_tuser);
               compare_field("slot", oldest.slot, rsp_tdata[3:0]);
               compare_field("status", oldest.status, rsp_tdata[5:4]);
               compare_field("pad", 0, rsp_tdata[7:6]);
               compare_field("last", oldest.last, rsp_tlast);
            end
         end
      end
      outstanding = due_results.size();
   end

endmodule

>>> sim/tb_top.sv
// Testbench top for the periodic timer slot table: stimulus, handshakes and verdict.
`timescale 1ns / 100ps

module tb_top;
   import ptst_pkg::*;

   // Command 3 is not defined by the table and must be dropped silently.
   localparam cmd_type CMD_IGNORED = 2'd3;
   // Cycles without any transfer before the run is declared hung.
   localparam int IDLE_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 128;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // [31:0] now_time, [63:32] period, [71:64] slot_index,
   // [72] has_handler, [73] has_context, [79:74] zero
   logic [79:0] req_tdata  = '0;
   // [1:0] command
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [3:0] slot, [5:4] status, [7:6] zero
   logic [7:0]  rsp_tdata;
   // [1:0] kind
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   int mismatches;
   int outstanding;

   // Bookkeeping for the sender and the closing summary.
   int burst_left    = 0;
   int counted_items = 0;
   int tick_count    = 0;
   int reg_count     = 0;
   int unreg_count   = 0;
   int ignored_count = 0;
   int results_seen  = 0;
   int fired_seen    = 0;
   int idle_cycles   = 0;

   // Receiver pattern: a mode is held for a random stretch of cycles.
   int ready_mode  = 0;
   int ready_left  = 0;
   int ready_phase = 0;

   always #5 clock = ~clock;

   periodic_timer_slot_table_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   ptst_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // Response side back-pressure. Mode 0 never stalls, mode 1 flips a coin
   // each cycle, mode 2 accepts one cycle in four, and mode 3 is a short hard
   // stall. Stretches are kept short enough that every phase of a tick scan
   // sees a stall sooner or later.
   always @(posedge clock) begin
      if (ready_left == 0) begin
         ready_mode  <= $urandom_range(0, 3);
         ready_left  <= $urandom_range(1, 30);
         ready_phase <= 0;
         rsp_tready  <= 1'b1;
      end else begin
         ready_left  <= ready_left - 1;
         ready_phase <= ready_phase + 1;
         case (ready_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= (ready_phase % 4 == 0);
            default: rsp_tready <= (ready_left > 6) ? 1'b1 : 1'b0;
         endcase
      end
   end

   // Result tally for the summary.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen <= results_seen + 1;
         if (rsp_tuser == KIND_FIRED) fired_seen <= fired_seen + 1;
      end
   end

   // Hang detector: any transfer on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offers one request and returns at the edge where it is transferred.
   // Requests go out in bursts; a gap with tvalid low separates bursts,
   // so tvalid is never lowered and raised in the same time step.
   task automatic send_item(input cmd_type cmd, input logic [31:0] now_ms,
                            input logic [31:0] period_ms, input logic [7:0] index,
                            input logic handler, input logic ctx_flag);
      int gap;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         gap = $urandom_range(1, 8);
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {6'b0, ctx_flag, handler, index, period_ms, now_ms};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left = burst_left - 1;
      case (cmd)
         CMD_TICK:  tick_count  = tick_count + 1;
         CMD_REG:   reg_count   = reg_count + 1;
         CMD_UNREG: unreg_count = unreg_count + 1;
         default:   ignored_count = ignored_count + 1;
      endcase
      if (cmd != CMD_IGNORED) counted_items = counted_items + 1;
   endtask

   // Holds the request channel quiet until every owed result has arrived.
   task automatic drain_results;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   initial begin
      logic [31:0] now_ms;
      logic [31:0] period_ms;
      logic [7:0]  index;
      int          pick;
      int          drains;

      drains = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part. A tick on an empty table gives only the closing result.
      send_item(CMD_TICK, 32'd0, 32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b1);
      // Unregister out of range: most negative, largest positive, first
      // index past the table and minus one; then a slot that is already free.
      send_item(CMD_UNREG, 32'hFFFF_FFFF, 32'd0, 8'h80, 1'b0, 1'b0);
      send_item(CMD_UNREG, 32'd0, 32'hFFFF_FFFF, 8'h7F, 1'b1, 1'b1);
      send_item(CMD_UNREG, 32'd0, 32'd0, SLOTS_IDX, 1'b0, 1'b0);
      send_item(CMD_UNREG, 32'd0, 32'd0, 8'hFF, 1'b0, 1'b0);
      send_item(CMD_UNREG, 32'd0, 32'd0, 8'(LAST_SLOT), 1'b0, 1'b0);
      // Register without a handler writes slot 0 but leaves it free, so the
      // next register reuses slot 0. That one has a zero period and never
      // fires; slot 1 lacks a context and slot 2 has the largest period.
      send_item(CMD_REG, 32'd0, 32'd5, 8'd0, 1'b0, 1'b1);
      send_item(CMD_REG, 32'd0, 32'd0, 8'd0, 1'b1, 1'b1);
      send_item(CMD_REG, 32'd0, 32'd1, 8'd0, 1'b1, 1'b0);
      send_item(CMD_REG, 32'd0, 32'hFFFF_FFFF, 8'd0, 1'b1, 1'b1);
      send_item(CMD_REG, 32'd0, 32'd10, 8'd0, 1'b1, 1'b1);
      // Elapsed equal to the period does not fire; one more does; then the
      // clock wraps and the modular difference makes slot 3 fire again.
      send_item(CMD_TICK, 32'd10, 32'd0, 8'd0, 1'b0, 1'b0);
      send_item(CMD_TICK, 32'd11, 32'd0, 8'd0, 1'b0, 1'b0);
      send_item(CMD_TICK, 32'd5, 32'd0, 8'd0, 1'b0, 1'b0);
      // An undefined command with every bit set is dropped without a result.
      send_item(CMD_IGNORED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b1);
      // Fill the rest of the table, then one more register hits a full table.
      for (int i = 4; i <= SLOTS; i++) send_item(CMD_REG, 32'd0, 32'd1, 8'd0, 1'b1, 1'b1);
      // Half the number range later almost every slot fires in one tick.
      send_item(CMD_TICK, 32'h8000_0000, 32'd0, 8'd0, 1'b0, 1'b0);
      send_item(CMD_TICK, 32'hFFFF_FFFF, 32'd0, 8'd0, 1'b0, 1'b0);

      // Random part. Time mostly creeps forward so periods expire naturally,
      // with an occasional jump anywhere or to just before the wrap point.
      now_ms = $urandom();
      counted_items = 0;
      while (counted_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            case ($urandom_range(0, 9))
               0:       now_ms = $urandom();
               1:       now_ms = 32'hFFFF_FFF0 + 32'($urandom_range(0, 15));
               default: now_ms = now_ms + 32'($urandom_range(0, 12));
            endcase
            send_item(CMD_TICK, now_ms, $urandom(), 8'($urandom()),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end else if (pick < 72) begin
            case ($urandom_range(0, 9))
               0:       period_ms = 32'd0;
               1:       period_ms = $urandom();
               2:       period_ms = 32'hFFFF_FFFF;
               default: period_ms = 32'($urandom_range(1, 20));
            endcase
            send_item(CMD_REG, $urandom(), period_ms, 8'($urandom()),
                      ($urandom_range(0, 7) != 0), ($urandom_range(0, 5) != 0));
         end else if (pick < 96) begin
            // Mostly real slot numbers so the table keeps churning.
            if ($urandom_range(0, 4) == 0) index = 8'($urandom());
            else index = 8'($urandom_range(0, SLOTS - 1));
            send_item(CMD_UNREG, $urandom(), $urandom(), index,
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end else begin
            send_item(CMD_IGNORED, $urandom(), $urandom(), 8'($urandom()),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end
         // Let the table run dry now and then, always at least once mid-run.
         if ((counted_items == RANDOM_ITEMS / 2 && drains == 0) ||
             $urandom_range(0, 49) == 0) begin
            drain_results();
            drains = drains + 1;
            burst_left = 0;
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      // Room for a stray result beyond the last expected one.
      repeat (40) @(posedge clock);

      $display("Covered %0d ticks, %0d registers, %0d unregisters, %0d undefined commands.",
               tick_count, reg_count, unreg_count, ignored_count);
      $display("Checked %0d results, %0d of them slot expiries; %0d drain pauses.",
               results_seen, fired_seen, drains);
      if (mismatches == 0 && outstanding == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
